// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge outside reset
`define PSP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition implies another in the same cycle
`define PSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/psp_pkg.sv =====
package psp_pkg;

	localparam int unsigned MAX_VIEWPORT = 4096;
	localparam int unsigned VP_W = 13;
	localparam int unsigned HS_W = $clog2(MAX_VIEWPORT) + 15;
	localparam int unsigned PA_W = HS_W + 32;
	localparam int unsigned WX_W = PA_W + 32;
	localparam int unsigned WY_W = WX_W + 32;
	localparam int unsigned NX_W = WX_W - 16;
	localparam int unsigned NY_W = WY_W - 32;
	localparam int unsigned QB = 41;
	localparam int unsigned QD = 4;
	localparam int unsigned PTR_W = $clog2(QD);
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [QB-1:0] TERM_CAP = {1'b1, {(QB-1){1'b0}}};
	localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DISTANCE,
		CFG_ASPECT,
		CFG_WIDTH,
		CFG_HEIGHT
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] cam_x;
		logic signed [31:0] cam_y;
		logic signed [31:0] cam_z;
		logic               last_in;
	} in_t;

	typedef struct packed {
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
		logic               zero_depth;
		logic               clamped;
		logic               last_out;
	} out_t;

	typedef struct packed {
		logic [31:0]     distance;
		logic [31:0]     aspect;
		logic [HS_W-1:0] half_w;
		logic [HS_W-1:0] half_h;
	} cfg_t;

	typedef struct packed {
		logic xn;
		logic yn;
		logic zn;
		logic xnz;
		logic ynz;
		logic zero;
		logic last;
	} side_t;

	typedef struct packed {
		logic [NX_W-1:0] nx;
		logic [NY_W-1:0] ny;
		logic [31:0]     zm;
		side_t           side;
	} entry_t;

	typedef struct packed {
		logic [31:0]   rx;
		logic [QB-1:0] dx;
		logic [31:0]   ry;
		logic [QB-1:0] dy;
		logic [31:0]   zm;
		logic          ovx;
		logic          ovy;
		side_t         side;
	} div_t;

	function automatic logic [HS_W-1:0] half_span(input logic [VP_W-1:0] size);
		logic [VP_W-1:0] s;
		s = size;
		if (s == '0) begin
			s = VP_W'(1);
		end
		if (s > VP_W'(MAX_VIEWPORT)) begin
			s = VP_W'(MAX_VIEWPORT);
		end
		return HS_W'(s - VP_W'(1)) << 15;
	endfunction

endpackage

// ===== rtl/core/psp_front.sv =====
module psp_front import psp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   in_valid,
	output logic   in_ready,
	input  in_t    in_data,
	input  logic   q_full,
	output logic   q_push,
	output entry_t q_data
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [31:0] xm_s1, ym_s1, zm_s1;
	logic [31:0] zm_s2, zm_s3, zm_s4, zm_s5, zm_s6;
	side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	logic [PA_W-1:0] px_s2, py_s2;
	logic [63:0] xl_s3, yl_s3;
	logic [PA_W-1:0] xh_s3, yh_s3;
	logic [WX_W-1:0] wx_s4, wy_s4;
	logic [NX_W-1:0] nx_s5, nx_s6;
	logic [63:0] y0_s5, y1_s5;
	logic [WX_W-33:0] y2_s5;
	logic [NY_W-1:0] ny_s6;
	logic [WY_W-1:0] ysum;

	assign en       = !v_s6 || !q_full;
	assign in_ready = en;
	assign q_push   = v_s6 && !q_full;
	assign q_data   = '{nx: nx_s6, ny: ny_s6, zm: zm_s6, side: side_s6};

	assign ysum = WY_W'(y0_s5) + WY_W'({y1_s5, 32'b0}) + {y2_s5, 64'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xm_s1 <= in_data.cam_x[31] ? 32'(-in_data.cam_x) : 32'(in_data.cam_x);
			ym_s1 <= in_data.cam_y[31] ? 32'(-in_data.cam_y) : 32'(in_data.cam_y);
			zm_s1 <= in_data.cam_z[31] ? 32'(-in_data.cam_z) : 32'(in_data.cam_z);
			side_s1.xn   <= in_data.cam_x[31];
			side_s1.yn   <= in_data.cam_y[31];
			side_s1.zn   <= in_data.cam_z[31];
			side_s1.xnz  <= in_data.cam_x != '0;
			side_s1.ynz  <= in_data.cam_y != '0;
			side_s1.zero <= in_data.cam_z == '0;
			side_s1.last <= in_data.last_in;

			px_s2   <= PA_W'(cfg.half_w) * PA_W'(xm_s1);
			py_s2   <= PA_W'(cfg.half_h) * PA_W'(ym_s1);
			zm_s2   <= zm_s1;
			side_s2 <= side_s1;

			xl_s3   <= 64'(px_s2[31:0]) * 64'(cfg.distance);
			xh_s3   <= PA_W'(px_s2[PA_W-1:32]) * PA_W'(cfg.distance);
			yl_s3   <= 64'(py_s2[31:0]) * 64'(cfg.distance);
			yh_s3   <= PA_W'(py_s2[PA_W-1:32]) * PA_W'(cfg.distance);
			zm_s3   <= zm_s2;
			side_s3 <= side_s2;

			wx_s4   <= WX_W'(xl_s3) + {xh_s3, 32'b0};
			wy_s4   <= WX_W'(yl_s3) + {yh_s3, 32'b0};
			zm_s4   <= zm_s3;
			side_s4 <= side_s3;

			nx_s5   <= wx_s4[WX_W-1:16];
			y0_s5   <= 64'(wy_s4[31:0]) * 64'(cfg.aspect);
			y1_s5   <= 64'(wy_s4[63:32]) * 64'(cfg.aspect);
			y2_s5   <= (WX_W-32)'(wy_s4[WX_W-1:64]) * (WX_W-32)'(cfg.aspect);
			zm_s5   <= zm_s4;
			side_s5 <= side_s4;

			nx_s6   <= nx_s5;
			ny_s6   <= ysum[WY_W-1:32];
			zm_s6   <= zm_s5;
			side_s6 <= side_s5;
		end
	end

endmodule

// ===== rtl/core/psp_fifo.sv =====
module psp_fifo import psp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	output logic   full,
	input  logic   pop,
	output logic   valid,
	output entry_t head
);

	entry_t mem_q [QD];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0] cnt_q;

	assign full  = cnt_q == (PTR_W+1)'(QD);
	assign valid = cnt_q != '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (PTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/core/psp_back.sv =====
module psp_back import psp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   q_valid,
	output logic   q_pop,
	input  entry_t q_data,
	output logic   out_valid,
	input  logic   out_ready,
	output out_t   out_data
);

	function automatic logic [32+QB-1:0] div_step(
		input logic [31:0]   rem,
		input logic [QB-1:0] dq,
		input logic [31:0]   d
	);
		logic [32:0] t;
		logic [32:0] r;
		t = {rem, dq[QB-1]};
		r = t - {1'b0, d};
		if (t >= {1'b0, d}) begin
			return {r[31:0], dq[QB-2:0], 1'b1};
		end
		return {t[31:0], dq[QB-2:0], 1'b0};
	endfunction

	logic en;
	logic [QB:0] v_s;
	div_t st_s [QB+1];
	logic res_v_q;
	out_t res_q;
	div_t fin;
	logic [QB-1:0] cx, cy;
	logic signed [QB+1:0] vx, vy, sxw, syw;
	logic fit_x, fit_y;
	out_t res_d;

	assign en        = !res_v_q || out_ready;
	assign q_pop     = en && q_valid;
	assign out_valid = res_v_q;
	assign out_data  = res_q;
	assign fin       = st_s[QB];

	always_comb begin
		cx = (fin.ovx || fin.dx > TERM_CAP) ? TERM_CAP : fin.dx;
		cy = (fin.ovy || fin.dy > TERM_CAP) ? TERM_CAP : fin.dy;
		vx = $signed((QB+2)'(cx));
		vy = $signed((QB+2)'(cy));
		if (fin.side.xn ^ fin.side.zn) begin
			vx = -vx;
		end
		if (fin.side.yn ^ fin.side.zn) begin
			vy = -vy;
		end
		sxw = $signed((QB+2)'(cfg.half_w)) + vx;
		syw = $signed((QB+2)'(cfg.half_h)) - vy;
		fit_x = &sxw[QB+1:31] || ~|sxw[QB+1:31];
		fit_y = &syw[QB+1:31] || ~|syw[QB+1:31];
		res_d.last_out = fin.side.last;
		if (fin.side.zero) begin
			res_d.zero_depth = 1'b1;
			res_d.clamped    = 1'b0;
			res_d.screen_x   = 32'(cfg.half_w);
			res_d.screen_y   = 32'(cfg.half_h);
			if (cfg.half_w != '0 && fin.side.xnz) begin
				res_d.screen_x = fin.side.xn ? S32_MIN : S32_MAX;
			end
			if (cfg.half_h != '0 && fin.side.ynz) begin
				res_d.screen_y = fin.side.yn ? S32_MAX : S32_MIN;
			end
		end else begin
			res_d.zero_depth = 1'b0;
			res_d.clamped    = !fit_x || !fit_y;
			res_d.screen_x   = fit_x ? sxw[31:0] : (sxw[QB+1] ? S32_MIN : S32_MAX);
			res_d.screen_y   = fit_y ? syw[31:0] : (syw[QB+1] ? S32_MIN : S32_MAX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s     <= '0;
			res_v_q <= 1'b0;
		end else if (en) begin
			v_s     <= {v_s[QB-1:0], q_valid};
			res_v_q <= v_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0].rx   <= q_data.nx[QB+31:QB];
			st_s[0].dx   <= q_data.nx[QB-1:0];
			st_s[0].ry   <= q_data.ny[QB+31:QB];
			st_s[0].dy   <= q_data.ny[QB-1:0];
			st_s[0].zm   <= q_data.zm;
			st_s[0].ovx  <= q_data.nx[NX_W-1:QB] >= (NX_W-QB)'(q_data.zm);
			st_s[0].ovy  <= q_data.ny[NY_W-1:QB] >= (NY_W-QB)'(q_data.zm);
			st_s[0].side <= q_data.side;
			for (int k = 1; k <= QB; k++) begin
				{st_s[k].rx, st_s[k].dx} <= div_step(st_s[k-1].rx, st_s[k-1].dx, st_s[k-1].zm);
				{st_s[k].ry, st_s[k].dy} <= div_step(st_s[k-1].ry, st_s[k-1].dy, st_s[k-1].zm);
				st_s[k].zm   <= st_s[k-1].zm;
				st_s[k].ovx  <= st_s[k-1].ovx;
				st_s[k].ovy  <= st_s[k-1].ovy;
				st_s[k].side <= st_s[k-1].side;
			end
			res_q <= res_d;
		end
	end

endmodule

// ===== rtl/core/perspective_screen_project_core.sv =====
// Projects one camera-space vertex per transfer to a Q16.16 screen position, taking a new
// vertex every clock while in_ready is high. The path has six front stages of magnitude,
// multiply and sum, a four-entry queue, then a divider that retires one quotient bit per stage
// over 41 stages and a saturating output register. Throughput stays at one vertex per cycle
// with out_ready high; the queue lets the front keep accepting while the output stalls, until
// it fills. Write the configuration registers only while no vertex is in flight.
`include "assert_macros.svh"

module perspective_screen_project_core import psp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_t                 out_data
);

	cfg_t cfg_q;
	logic q_full, q_push, q_valid, q_pop;
	entry_t q_in, q_head;
	logic out_zero, out_clamp, out_at_bound;

	assign out_zero     = out_valid && out_data.zero_depth;
	assign out_clamp    = out_valid && out_data.clamped;
	assign out_at_bound = out_data.screen_x == S32_MAX || out_data.screen_x == S32_MIN ||
		out_data.screen_y == S32_MAX || out_data.screen_y == S32_MIN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.distance <= 32'd65536;
			cfg_q.aspect   <= 32'd87381;
			cfg_q.half_w   <= half_span(VP_W'(640));
			cfg_q.half_h   <= half_span(VP_W'(480));
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DISTANCE: cfg_q.distance <= cfg_data;
				CFG_ASPECT:   cfg_q.aspect   <= cfg_data;
				CFG_WIDTH:    cfg_q.half_w   <= half_span(cfg_data[VP_W-1:0]);
				CFG_HEIGHT:   cfg_q.half_h   <= half_span(cfg_data[VP_W-1:0]);
				default: ;
			endcase
		end
	end

	psp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_in)
	);

	psp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	psp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_data    (q_head),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	`PSP_ASSERT_IMP(a_push_room, clk, arst_n, q_push, !q_full, "push into full queue")
	`PSP_ASSERT_IMP(a_zero_no_clamp, clk, arst_n, out_zero, !out_data.clamped, "zero depth with clamp")
	`PSP_ASSERT_IMP(a_clamp_bound, clk, arst_n, out_clamp, out_at_bound, "clamp without bound")

endmodule

// ===== dv/tb_perspective_screen_project_core.sv =====
`timescale 1ns / 100ps

module tb_perspective_screen_project_core;
	import psp_pkg::*;

	localparam int DRAIN_CYCLES = 80;
	localparam int STALL_LIMIT = 20000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	in_t                  in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_t                 out_data;

	perspective_screen_project_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	logic [31:0] distance_q;
	logic [31:0] aspect_q;
	logic [12:0] width_q;
	logic [12:0] height_q;

	out_t screen_q[$];
	int   errors;
	int   vertex_cnt;
	int   screen_cnt;
	int   idle_cycles;
	int   send_idle_pct;
	int   recv_stall_pct;
	bit   hold_off;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] span_half(input logic [12:0] size);
		logic [63:0] s;
		s = 64'(size);
		if (s == 64'd0) begin
			s = 64'd1;
		end
		if (s > 64'(MAX_VIEWPORT)) begin
			s = 64'(MAX_VIEWPORT);
		end
		return (s - 64'd1) << 15;
	endfunction

	function automatic out_t project_vertex(input in_t v);
		out_t r;
		logic [31:0]  xm, ym, zm;
		logic         xn, yn, zn, clip;
		logic [63:0]  a, b;
		logic [127:0] tx, ty;
		logic [63:0]  cx, cy;
		longint       vx, vy, sx, sy;
		xn = v.cam_x[31];
		yn = v.cam_y[31];
		zn = v.cam_z[31];
		xm = xn ? -v.cam_x : v.cam_x;
		ym = yn ? -v.cam_y : v.cam_y;
		zm = zn ? -v.cam_z : v.cam_z;
		a = span_half(width_q);
		b = span_half(height_q);
		clip = 1'b0;
		if (zm == 0) begin
			sx = a;
			sy = b;
			if (a != 0 && xm != 0) begin
				sx = xn ? -64'sd2147483648 : 64'sd2147483647;
			end
			if (b != 0 && ym != 0) begin
				sy = yn ? 64'sd2147483647 : -64'sd2147483648;
			end
		end else begin
			tx = (128'(a) * 128'(xm) * 128'(distance_q)) / (128'(zm) << 16);
			ty = (128'(b) * 128'(ym) * 128'(distance_q) * 128'(aspect_q)) / (128'(zm) << 32);
			cx = (tx > 128'h100_0000_0000) ? 64'h100_0000_0000 : tx[63:0];
			cy = (ty > 128'h100_0000_0000) ? 64'h100_0000_0000 : ty[63:0];
			vx = (xn != zn) ? -longint'(cx) : longint'(cx);
			vy = (yn != zn) ? -longint'(cy) : longint'(cy);
			sx = longint'(a) + vx;
			sy = longint'(b) - vy;
			if (sx > 64'sd2147483647) begin
				sx = 64'sd2147483647;
				clip = 1'b1;
			end else if (sx < -64'sd2147483648) begin
				sx = -64'sd2147483648;
				clip = 1'b1;
			end
			if (sy > 64'sd2147483647) begin
				sy = 64'sd2147483647;
				clip = 1'b1;
			end else if (sy < -64'sd2147483648) begin
				sy = -64'sd2147483648;
				clip = 1'b1;
			end
		end
		r.screen_x = sx[31:0];
		r.screen_y = sy[31:0];
		r.zero_depth = (zm == 0);
		r.clamped = clip;
		r.last_out = v.last_in;
		return r;
	endfunction

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_DISTANCE: distance_q = val;
			CFG_ASPECT:   aspect_q = val;
			CFG_WIDTH:    width_q = val[12:0];
			CFG_HEIGHT:   height_q = val[12:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic send_vertex(input in_t v);
		while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= v;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		screen_q.push_back(project_vertex(v));
		vertex_cnt++;
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (screen_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(5, 0))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(1, 0) ? 32'($urandom_range(4, 0)) : -32'($urandom_range(4, 0));
			3: return $urandom;
			default: return 32'($signed($urandom_range(32'h0040_0000, 0)) - 32'sh0020_0000);
		endcase
	endfunction

	function automatic in_t random_vertex();
		in_t v;
		v.cam_x = pick_coord();
		v.cam_y = pick_coord();
		v.cam_z = ($urandom_range(15, 0) == 0) ? 32'h0 : pick_coord();
		v.last_in = 1'($urandom_range(1, 0));
		return v;
	endfunction

	task automatic test_directed();
		logic [31:0] edges[5];
		in_t v;
		edges = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 32'hffff_0000};
		for (int i = 0; i < 5; i++) begin
			for (int j = 0; j < 4; j++) begin
				v.cam_x = edges[i];
				v.cam_y = edges[(i + j) % 5];
				v.cam_z = edges[(i + 2 * j) % 5];
				v.last_in = j[0];
				send_vertex(v);
			end
		end
		settle();
	endtask

	task automatic test_random(input int n);
		for (int i = 0; i < n; i++) begin
			send_vertex(random_vertex());
		end
		settle();
	endtask

	task automatic test_config_sweep();
		logic [31:0] d_set[4];
		logic [31:0] a_set[4];
		logic [31:0] w_set[5];
		d_set = '{32'd1, 32'hffff_ffff, 32'd65536, 32'h0};
		a_set = '{32'hffff_ffff, 32'd1, 32'd87381, 32'h0};
		w_set = '{32'd1, 32'd4096, 32'd0, 32'h1fff, 32'd4097};
		for (int k = 0; k < 5; k++) begin
			write_reg(CFG_DISTANCE, d_set[k % 4]);
			write_reg(CFG_ASPECT, a_set[k % 4]);
			write_reg(CFG_WIDTH, w_set[k]);
			write_reg(CFG_HEIGHT, w_set[4 - k]);
			test_random(60);
		end
		write_reg(CFG_DISTANCE, $urandom);
		write_reg(CFG_ASPECT, $urandom_range(32'h0004_0000, 1));
		write_reg(CFG_WIDTH, $urandom_range(4096, 1));
		write_reg(CFG_HEIGHT, $urandom_range(4096, 1));
		test_random(60);
		write_reg(CFG_DISTANCE, 32'd65536);
		write_reg(CFG_ASPECT, 32'd87381);
		write_reg(CFG_WIDTH, 32'd640);
		write_reg(CFG_HEIGHT, 32'd480);
	endtask

	task automatic test_idle_phases();
		send_idle_pct = 83;
		recv_stall_pct = 0;
		test_random(200);
		send_idle_pct = 0;
		recv_stall_pct = 83;
		test_random(200);
		send_idle_pct = 34;
		recv_stall_pct = 34;
		test_random(200);
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_backpressure();
		hold_off = 1'b1;
		for (int i = 0; i < 120; i++) begin
			send_vertex(random_vertex());
		end
		settle();
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_off) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= !(recv_stall_pct != 0 && $urandom_range(99, 0) < recv_stall_pct);
		end
	end

	initial begin
		hold_off = 1'b0;
		wait (arst_n);
		forever begin
			wait (hold_off);
			repeat (400) @(negedge clk);
			hold_off = 1'b0;
		end
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			screen_cnt++;
			if (screen_q.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected transfer: %h", out_data);
				end
			end else begin
				want = screen_q.pop_front();
				if (out_data.screen_x !== want.screen_x || out_data.screen_y !== want.screen_y ||
						out_data.zero_depth !== want.zero_depth ||
						out_data.clamped !== want.clamped ||
						out_data.last_out !== want.last_out) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch: exp x=%h y=%h z=%b c=%b l=%b got x=%h y=%h z=%b c=%b l=%b",
							want.screen_x, want.screen_y, want.zero_depth, want.clamped,
							want.last_out, out_data.screen_x, out_data.screen_y,
							out_data.zero_depth, out_data.clamped, out_data.last_out);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		errors = 0;
		vertex_cnt = 0;
		screen_cnt = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		distance_q = 32'd65536;
		aspect_q = 32'd87381;
		width_q = 13'd640;
		height_q = 13'd480;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_config_sweep();
		test_idle_phases();
		test_backpressure();
		test_random(470);
		if (screen_q.size() != 0) begin
			errors++;
		end
		$display("covered %0d vertices, %0d screen transfers: edge coordinates, zero depth,",
			vertex_cnt, screen_cnt);
		$display("register extremes, idle and stall phases, long output hold-off");
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/psp_pkg.sv
rtl/core/psp_front.sv
rtl/core/psp_fifo.sv
rtl/core/psp_back.sv
rtl/core/perspective_screen_project_core.sv
dv/tb_perspective_screen_project_core.sv
